// ===== design/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

	localparam int SZW  = 11;
	localparam int IDPW = 16;
	localparam int BAW  = 10;

	typedef enum logic [1:0] {
		K_ABSENT = 2'd0,
		K_FREE   = 2'd1,
		K_USED   = 2'd2,
		K_SPLIT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RS_OK        = 3'd0,
		RS_NOSPACE   = 3'd1,
		RS_BADSIZE   = 3'd2,
		RS_UNKNOWN   = 3'd3,
		RS_EXHAUSTED = 3'd4
	} res_code_t;

	typedef enum logic [4:0] {
		OP_NOP       = 5'd0,
		OP_CLR_START = 5'd1,
		OP_CLR_STEP  = 5'd2,
		OP_LOAD      = 5'd3,
		OP_A_GRANT   = 5'd4,
		OP_A_SPLIT0  = 5'd5,
		OP_A_SPLIT1  = 5'd6,
		OP_A_SPLIT2  = 5'd7,
		OP_A_DESC    = 5'd8,
		OP_A_BT      = 5'd9,
		OP_S_STEP    = 5'd10,
		OP_S_HIT     = 5'd11,
		OP_M_STEP    = 5'd12,
		OP_M_W0      = 5'd13,
		OP_M_W1      = 5'd14,
		OP_M_W2      = 5'd15,
		OP_EMIT      = 5'd16
	} dp_op_t;

	typedef struct packed {
		dp_op_t    op;
		logic      res_set;
		res_code_t res_code;
	} dp_cmd_t;

	typedef struct packed {
		logic cmd_free;
		logic bad_size;
		logic exhausted;
		logic rid_zero;
		logic a_grant;
		logic a_fail;
		logic a_split;
		logic a_at_root;
		logic a_odd;
		logic clr_last;
		logic s_hit;
		logic s_end;
		logic m_hit;
		logic m_end;
		logic m_last;
	} dp_flag_t;

	// largest power of two strictly below s, zero for s of one
	function automatic logic [SZW-1:0] left_part(input logic [SZW-1:0] s);
		logic [SZW-1:0] sm;
		logic [SZW-1:0] p;
		sm = s - 1'b1;
		p  = '0;
		if (s > SZW'(1)) begin
			for (int i = 0; i < SZW; i++) begin
				if (sm[i]) begin
					p    = '0;
					p[i] = 1'b1;
				end
			end
		end
		return p;
	endfunction

endpackage

// ===== design/bba_ctrl.sv =====
`timescale 1ns / 1ps
module bba_ctrl
	import bba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_flag_t flag,
	output dp_cmd_t  cmd
);

	typedef enum logic [12:0] {
		ST_CLR  = 13'b0000000000001,
		ST_IDLE = 13'b0000000000010,
		ST_DISP = 13'b0000000000100,
		ST_ARD  = 13'b0000000001000,
		ST_AEV  = 13'b0000000010000,
		ST_ASP1 = 13'b0000000100000,
		ST_ASP2 = 13'b0000001000000,
		ST_ABT  = 13'b0000010000000,
		ST_FSC  = 13'b0000100000000,
		ST_MSC  = 13'b0001000000000,
		ST_MW1  = 13'b0010000000000,
		ST_MW2  = 13'b0100000000000,
		ST_DONE = 13'b1000000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE) || cfg_we;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt    = state_q;
		cmd.op       = OP_NOP;
		cmd.res_set  = 1'b0;
		cmd.res_code = RS_OK;
		case (state_q)
			ST_CLR: begin
				if (cfg_we) begin
					cmd.op = OP_CLR_START;
				end else begin
					cmd.op = OP_CLR_STEP;
					if (flag.clr_last) state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cfg_we) begin
					cmd.op    = OP_CLR_START;
					state_nxt = ST_CLR;
				end else if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = ST_DISP;
				end
			end
			ST_DISP: begin
				if (flag.cmd_free) begin
					if (flag.rid_zero) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = RS_UNKNOWN;
						state_nxt    = ST_DONE;
					end else begin
						state_nxt = ST_FSC;
					end
				end else if (flag.bad_size) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = RS_BADSIZE;
					state_nxt    = ST_DONE;
				end else if (flag.exhausted) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = RS_EXHAUSTED;
					state_nxt    = ST_DONE;
				end else begin
					state_nxt = ST_ARD;
				end
			end
			ST_ARD: begin
				state_nxt = ST_AEV;
			end
			ST_AEV: begin
				if (flag.a_grant) begin
					cmd.op    = OP_A_GRANT;
					state_nxt = ST_DONE;
				end else if (flag.a_fail) begin
					state_nxt = ST_ABT;
				end else if (flag.a_split) begin
					cmd.op    = OP_A_SPLIT0;
					state_nxt = ST_ASP1;
				end else begin
					cmd.op    = OP_A_DESC;
					state_nxt = ST_ARD;
				end
			end
			ST_ASP1: begin
				cmd.op    = OP_A_SPLIT1;
				state_nxt = ST_ASP2;
			end
			ST_ASP2: begin
				cmd.op    = OP_A_SPLIT2;
				state_nxt = ST_ARD;
			end
			ST_ABT: begin
				if (flag.a_at_root) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = RS_NOSPACE;
					state_nxt    = ST_DONE;
				end else begin
					cmd.op = OP_A_BT;
					if (!flag.a_odd) state_nxt = ST_ARD;
				end
			end
			ST_FSC: begin
				if (flag.s_hit) begin
					cmd.op    = OP_S_HIT;
					state_nxt = ST_MSC;
				end else if (flag.s_end) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = RS_UNKNOWN;
					state_nxt    = ST_DONE;
				end else begin
					cmd.op = OP_S_STEP;
				end
			end
			ST_MSC: begin
				if (flag.m_hit) begin
					cmd.op    = OP_M_W0;
					state_nxt = ST_MW1;
				end else if (flag.m_end) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = RS_OK;
					state_nxt    = ST_DONE;
				end else begin
					cmd.op = OP_M_STEP;
				end
			end
			ST_MW1: begin
				cmd.op    = OP_M_W1;
				state_nxt = ST_MW2;
			end
			ST_MW2: begin
				cmd.op = OP_M_W2;
				if (flag.m_last) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = RS_OK;
					state_nxt    = ST_DONE;
				end else begin
					state_nxt = ST_MSC;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op    = OP_EMIT;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (!out_stall)   out_valid_q <= 1'b0;
		end
	end

	a_no_emit_over_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> (cmd.op != OP_EMIT))
		else $error("result overwritten while stalled");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |=> (state_q == ST_DISP))
		else $error("load did not dispatch");

	a_grant_not_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_A_GRANT) |-> !flag.exhausted)
		else $error("grant with ids exhausted");

endmodule

// ===== design/bba_dp.sv =====
`timescale 1ns / 1ps
module bba_dp
	import bba_pkg::*;
#(
	parameter int MAX_DEPTH = 10,
	parameter int ID_WIDTH  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [SZW-1:0]   cfg_wdata,
	input  logic             in_command,
	input  logic [SZW-1:0]   in_request_size,
	input  logic [IDPW-1:0]  in_release_id,
	input  dp_cmd_t          cmd,
	output dp_flag_t         flag,
	output logic [2:0]       out_status,
	output logic [IDPW-1:0]  out_granted_id,
	output logic [BAW-1:0]   out_base,
	output logic [SZW-1:0]   out_size
);

	localparam int NW    = MAX_DEPTH + 1;
	localparam int NSLOT = 2 ** NW;
	localparam int DW    = $clog2(MAX_DEPTH + 1);
	localparam int CW    = (ID_WIDTH > IDPW) ? ID_WIDTH : IDPW;
	localparam logic [SZW:0] LIM = (MAX_DEPTH >= SZW) ? (SZW+1)'(2 ** SZW)
	                                                 : (SZW+1)'(2 ** MAX_DEPTH);
	localparam logic [NW-1:0] MRG_START = {1'b0, {(NW-1){1'b1}}};

	kind_t               kind_mem [NSLOT];
	logic [ID_WIDTH-1:0] owner_mem [NSLOT];
	kind_t               rda_q, rdb_q;
	logic [ID_WIDTH-1:0] rdo_q;

	logic [SZW-1:0]      ts_q;
	logic                cmd_q;
	logic [SZW-1:0]      req_q;
	logic [IDPW-1:0]     rid_q;
	logic [NW-1:0]       idx_q;
	logic [DW-1:0]       depth_q;
	logic [SZW-1:0]      s_q, b_q;
	logic [SZW-1:0]      stk_s_q [MAX_DEPTH+1];
	logic [SZW-1:0]      stk_b_q [MAX_DEPTH+1];
	logic [ID_WIDTH-1:0] next_id_q;
	logic                v_s1;
	logic [NW-1:0]       a_s1;
	res_code_t           res_status_q, out_status_q;
	logic [IDPW-1:0]     res_gid_q, out_gid_q;
	logic [SZW-1:0]      res_base_q, out_base_q;
	logic [SZW-1:0]      res_size_q, out_size_q;

	logic [SZW-1:0]      rs, p, ps, pb, pp;
	logic [DW-1:0]       dm1;
	logic [ID_WIDTH-1:0] nid_inc;
	logic                fits;
	logic [NW-1:0]       ra, rb, wa;
	logic                we, own_we;
	kind_t               wd;

	always_comb begin
		if (ts_q == '0)                rs = SZW'(1);
		else if ({1'b0, ts_q} > LIM)   rs = LIM[SZW-1:0];
		else                           rs = ts_q;
	end

	assign p       = left_part(s_q);
	assign dm1     = depth_q - 1'b1;
	assign ps      = stk_s_q[dm1];
	assign pb      = stk_b_q[dm1];
	assign pp      = left_part(ps);
	assign nid_inc = next_id_q + 1'b1;
	assign fits    = (req_q <= s_q) && (req_q > p);

	assign ra = (cmd.op == OP_M_STEP) ? {idx_q[NW-2:0], 1'b0} : idx_q;
	assign rb = {idx_q[NW-2:0], 1'b1};

	always_comb begin
		we     = 1'b0;
		own_we = 1'b0;
		wa     = idx_q;
		wd     = K_ABSENT;
		case (cmd.op)
			OP_CLR_STEP: begin
				we = 1'b1;
				wd = (idx_q == NW'(1)) ? K_FREE : K_ABSENT;
			end
			OP_A_GRANT: begin
				we     = 1'b1;
				own_we = 1'b1;
				wd     = K_USED;
			end
			OP_A_SPLIT0: begin
				we = 1'b1;
				wd = K_SPLIT;
			end
			OP_A_SPLIT1: begin
				we = 1'b1;
				wa = {idx_q[NW-2:0], 1'b0};
				wd = K_FREE;
			end
			OP_A_SPLIT2: begin
				we = 1'b1;
				wa = {idx_q[NW-2:0], 1'b1};
				wd = K_FREE;
			end
			OP_S_HIT, OP_M_W0: begin
				we = 1'b1;
				wa = a_s1;
				wd = K_FREE;
			end
			OP_M_W1: begin
				we = 1'b1;
				wa = {a_s1[NW-2:0], 1'b0};
			end
			OP_M_W2: begin
				we = 1'b1;
				wa = {a_s1[NW-2:0], 1'b1};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)     kind_mem[wa]  <= wd;
		if (own_we) owner_mem[wa] <= nid_inc;
		rda_q <= kind_mem[ra];
		rdb_q <= kind_mem[rb];
		rdo_q <= owner_mem[ra];
	end

	always_comb begin
		flag.cmd_free  = cmd_q;
		flag.bad_size  = (req_q == '0) || (req_q > rs);
		flag.exhausted = &next_id_q;
		flag.rid_zero  = (rid_q == '0);
		flag.a_grant   = fits && (rda_q == K_FREE);
		flag.a_fail    = fits ? (rda_q != K_FREE)
		                      : ((req_q > p) || (rda_q == K_USED) || idx_q[NW-1]);
		flag.a_split   = !fits && !flag.a_fail && (rda_q != K_SPLIT);
		flag.a_at_root = (idx_q == NW'(1));
		flag.a_odd     = idx_q[0];
		flag.clr_last  = &idx_q;
		flag.s_hit     = v_s1 && (rda_q == K_USED) && (CW'(rdo_q) == CW'(rid_q));
		flag.s_end     = v_s1 && (&a_s1) && !flag.s_hit;
		flag.m_hit     = v_s1 && (rda_q == K_FREE) && (rdb_q == K_FREE);
		flag.m_end     = v_s1 && (a_s1 == NW'(1)) && !flag.m_hit;
		flag.m_last    = (a_s1 == NW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q      <= SZW'(1024);
			idx_q     <= '0;
			depth_q   <= '0;
			next_id_q <= '0;
			v_s1      <= 1'b0;
			a_s1      <= '0;
		end else begin
			if (cfg_we) ts_q <= cfg_wdata;
			case (cmd.op)
				OP_CLR_START: idx_q <= '0;
				OP_CLR_STEP:  idx_q <= idx_q + 1'b1;
				OP_LOAD: begin
					idx_q   <= NW'(1);
					depth_q <= '0;
					v_s1    <= 1'b0;
				end
				OP_A_GRANT: next_id_q <= nid_inc;
				OP_A_SPLIT2, OP_A_DESC: begin
					idx_q   <= {idx_q[NW-2:0], 1'b0};
					depth_q <= depth_q + 1'b1;
				end
				OP_A_BT: begin
					if (idx_q[0]) begin
						idx_q   <= idx_q >> 1;
						depth_q <= dm1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				OP_S_STEP: begin
					v_s1 <= (idx_q != '0);
					a_s1 <= idx_q;
					if (idx_q != '0) idx_q <= idx_q + 1'b1;
				end
				OP_S_HIT: begin
					idx_q <= MRG_START;
					v_s1  <= 1'b0;
				end
				OP_M_STEP: begin
					v_s1 <= (idx_q != '0);
					a_s1 <= idx_q;
					if (idx_q != '0) idx_q <= idx_q - 1'b1;
				end
				OP_M_W2: begin
					idx_q <= a_s1 - 1'b1;
					v_s1  <= 1'b0;
				end
				default: begin
					v_s1 <= v_s1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cmd_q <= in_command;
				req_q <= in_request_size;
				rid_q <= in_release_id;
				s_q   <= rs;
				b_q   <= '0;
			end
			OP_A_SPLIT2, OP_A_DESC: begin
				stk_s_q[depth_q] <= s_q;
				stk_b_q[depth_q] <= b_q;
				s_q              <= p;
			end
			OP_A_BT: begin
				if (idx_q[0]) begin
					s_q <= ps;
					b_q <= pb;
				end else begin
					s_q <= ps - pp;
					b_q <= pb + pp;
				end
			end
			OP_A_GRANT: begin
				res_status_q <= RS_OK;
				res_gid_q    <= IDPW'(nid_inc);
				res_base_q   <= b_q;
				res_size_q   <= s_q;
			end
			OP_EMIT: begin
				out_status_q <= res_status_q;
				out_gid_q    <= res_gid_q;
				out_base_q   <= res_base_q;
				out_size_q   <= res_size_q;
			end
			default: begin
				s_q <= s_q;
			end
		endcase
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			res_gid_q    <= '0;
			res_base_q   <= '0;
			res_size_q   <= '0;
		end
	end

	assign out_status     = out_status_q;
	assign out_granted_id = out_gid_q;
	assign out_base       = out_base_q[BAW-1:0];
	assign out_size       = out_size_q;

	a_grant_bumps_id: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_A_GRANT) |=> (next_id_q == $past(nid_inc)))
		else $error("id counter not advanced on grant");

	a_desc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_A_DESC || cmd.op == OP_A_SPLIT0) |-> !idx_q[NW-1])
		else $error("descent below deepest level");

	a_split_from_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_A_SPLIT0) |-> (rda_q != K_USED && rda_q != K_SPLIT))
		else $error("split of a used or split node");

endmodule

// ===== design/buddy_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// after reset or a total_size write, clearing sweeps all 2^(MAX_DEPTH+1) slots (2048 by default)
// one item in flight; the result waits in an output register while the next item is taken
// allocate: dispatch, read and evaluate per node, three writes per split, backtrack step per level
// free: linear scan up to slot 2^(MAX_DEPTH+1)-1; on a hit, a merge sweep from node 2^MAX_DEPTH-1
//   down to the root; each merge writes three nodes through the node table's single write port
// asynchronous active-low reset; the id counter survives a total_size write
module buddy_block_allocator_unit
	import bba_pkg::*;
#(
	parameter int MAX_DEPTH = 10,
	parameter int ID_WIDTH  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [SZW-1:0]  cfg_wdata,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            command,
	input  logic [SZW-1:0]  request_size,
	input  logic [IDPW-1:0] release_id,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      status,
	output logic [IDPW-1:0] granted_id,
	output logic [BAW-1:0]  base_address,
	output logic [SZW-1:0]  block_size
);

	dp_cmd_t  cmd;
	dp_flag_t flag;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flag      (flag),
		.cmd       (cmd)
	);

	bba_dp #(
		.MAX_DEPTH (MAX_DEPTH),
		.ID_WIDTH  (ID_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_command      (command),
		.in_request_size (request_size),
		.in_release_id   (release_id),
		.cmd             (cmd),
		.flag            (flag),
		.out_status      (status),
		.out_granted_id  (granted_id),
		.out_base        (base_address),
		.out_size        (block_size)
	);

endmodule
